// File: rtl/u8d_pkg.sv
// Shared types, constants and decode functions for the UTF-8 stream decoder.
`default_nettype none

package u8d_pkg;

  // Default depth of the queue between front and back
  localparam int unsigned U8D_QUEUE_DEPTH = 4;

  // Replacement character U+FFFD
  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  // Kinds of work the front hands to the back
  typedef enum logic [1:0] {
    JOB_CP,   // one result: the byte itself or a replacement
    JOB_SEQ,  // one result: decode a complete multi-byte sequence
    JOB_CUT   // sequence cut at buffer end: replacement, then rescan the tail
  } job_kind_t;

  typedef struct packed {
    job_kind_t       kind;
    logic            rep;   // JOB_CP: emit a replacement instead of seq[0]
    logic [2:0]      len;   // JOB_SEQ: sequence length, JOB_CUT: bytes held
    logic [3:0][7:0] seq;   // seq[0] is the lead byte
  } job_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        rep;
  } res_t;

  // Sequence length announced by a lead byte, 0 for an invalid lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if (b[7] == 1'b0)            n = 3'd1;
    else if (b[7:5] == 3'b110)   n = 3'd2;
    else if (b[7:4] == 4'b1110)  n = 3'd3;
    else if (b[7:3] == 5'b11110) n = 3'd4;
    else                         n = 3'd0;
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Decode n bytes; returns {ok, code point}
  function automatic logic [21:0] decode_seq(input logic [3:0][7:0] b,
                                             input logic [2:0] n);
    logic [20:0] v;
    logic        ok;
    v  = '0;
    ok = 1'b1;
    case (n)
      3'd1: begin
        v = {13'b0, b[0]};
      end
      3'd2: begin
        ok = is_cont(b[1]);
        v  = {10'b0, b[0][4:0], b[1][5:0]};
        if (v < 21'h80) ok = 1'b0;
      end
      3'd3: begin
        ok = is_cont(b[1]) && is_cont(b[2]);
        v  = {5'b0, b[0][3:0], b[1][5:0], b[2][5:0]};
        if (v < 21'h800) ok = 1'b0;
        if (v >= 21'h00D800 && v <= 21'h00DFFF) ok = 1'b0;
      end
      3'd4: begin
        ok = is_cont(b[1]) && is_cont(b[2]) && is_cont(b[3]);
        v  = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
        if (v < 21'h10000) ok = 1'b0;
        if (v > 21'h10FFFF) ok = 1'b0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    return {ok, v};
  endfunction

  // One tail byte on its own: ASCII passes, anything else is replaced
  function automatic res_t single_res(input logic [7:0] b);
    res_t r;
    if (b[7] == 1'b0) r = '{cp: {13'b0, b}, rep: 1'b0};
    else              r = '{cp: REPL_CP, rep: 1'b1};
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/u8d_fifo.sv
// Small job queue between the decoder front and back.
`default_nettype none

module u8d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  not_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// File: rtl/u8d_front.sv
// Decoder front: accepts bytes, gathers sequences and queues jobs.
`default_nettype none

module u8d_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // [7:0] byte_in
  input  wire logic          s_tlast,   // last_byte
  input  wire logic          q_full,
  output logic               push,
  output u8d_pkg::job_t      push_job
);

  import u8d_pkg::*;

  logic [7:0] held [3];
  logic [2:0] exp_len;
  logic [1:0] held_count;

  logic [2:0]      exp_len_next;
  logic [1:0]      held_count_next;
  logic            hold_wr;
  logic            accept;
  logic [2:0]      lead_len;
  logic [2:0]      total;
  logic [3:0][7:0] seq;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign lead_len = lead_length(s_tdata);
  assign total    = {1'b0, held_count} + 3'd1;

  // Assemble held bytes plus the incoming byte
  always_comb begin
    seq = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < held_count) seq[i] = held[i];
    end
    seq[held_count] = s_tdata;
  end

  // Classify the byte against the open sequence
  always_comb begin
    push            = 1'b0;
    push_job        = '{kind: JOB_CP, rep: 1'b1, len: 3'd1, seq: {24'b0, s_tdata}};
    exp_len_next    = exp_len;
    held_count_next = held_count;
    hold_wr         = 1'b0;
    if (accept) begin
      if (exp_len == 3'd0) begin
        if (lead_len == 3'd1) begin
          push         = 1'b1;
          push_job.rep = 1'b0;
        end else if (lead_len == 3'd0 || s_tlast) begin
          push = 1'b1;
        end else begin
          hold_wr         = 1'b1;
          held_count_next = 2'd1;
          exp_len_next    = lead_len;
        end
      end else if (total >= exp_len) begin
        push            = 1'b1;
        push_job        = '{kind: JOB_SEQ, rep: 1'b0, len: exp_len, seq: seq};
        exp_len_next    = 3'd0;
        held_count_next = 2'd0;
      end else if (s_tlast) begin
        push            = 1'b1;
        push_job        = '{kind: JOB_CUT, rep: 1'b1, len: total, seq: seq};
        exp_len_next    = 3'd0;
        held_count_next = 2'd0;
      end else begin
        hold_wr         = 1'b1;
        held_count_next = held_count + 2'd1;
      end
    end
  end

  // Hold sequence bytes
  always_ff @(posedge clk) begin
    if (hold_wr) held[held_count] <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len    <= 3'd0;
      held_count <= 2'd0;
    end else begin
      exp_len    <= exp_len_next;
      held_count <= held_count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/u8d_back.sv
// Decoder back: decodes queued jobs and streams out one code point a beat.
`default_nettype none

module u8d_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire u8d_pkg::job_t q_head,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [23:0]        m_tdata,   // [20:0] code_point, [23:21] zero
  output logic               m_tuser,   // replaced
  output logic               m_tlast    // end_of_run
);

  import u8d_pkg::*;

  res_t [2:0]  res;
  logic [1:0]  res_cnt;
  logic [1:0]  idx;
  logic [21:0] dec;
  logic [21:0] dec_tail;
  logic [2:0]  tail_len;
  logic        load;
  logic        last_slot;
  logic [20:0] cp_q;

  // Work out every result of the job at the queue head
  always_comb begin
    res      = '0;
    res_cnt  = 2'd1;
    dec      = decode_seq(q_head.seq, q_head.len);
    dec_tail = decode_seq({16'b0, q_head.seq[2], q_head.seq[1]}, 3'd2);
    tail_len = lead_length(q_head.seq[1]);
    case (q_head.kind)
      JOB_CP: begin
        if (q_head.rep) res[0] = '{cp: REPL_CP, rep: 1'b1};
        else            res[0] = '{cp: {13'b0, q_head.seq[0]}, rep: 1'b0};
      end
      JOB_SEQ: begin
        if (dec[21]) res[0] = '{cp: dec[20:0], rep: 1'b0};
        else         res[0] = '{cp: REPL_CP, rep: 1'b1};
      end
      JOB_CUT: begin
        res[0] = '{cp: REPL_CP, rep: 1'b1};
        if (q_head.len == 3'd2) begin
          res[1]  = single_res(q_head.seq[1]);
          res_cnt = 2'd2;
        end else if (tail_len == 3'd2) begin
          if (dec_tail[21]) res[1] = '{cp: dec_tail[20:0], rep: 1'b0};
          else              res[1] = '{cp: REPL_CP, rep: 1'b1};
          res_cnt = 2'd2;
        end else begin
          res[1]  = single_res(q_head.seq[1]);
          res[2]  = single_res(q_head.seq[2]);
          res_cnt = 2'd3;
        end
      end
      default: begin
        res[0] = '{cp: REPL_CP, rep: 1'b1};
      end
    endcase
  end

  assign load      = !m_tvalid || m_tready;
  assign last_slot = (idx == res_cnt - 2'd1);
  assign pop       = load && q_valid && last_slot;
  assign m_tdata   = {3'b0, cp_q};

  // Output register: load the next result whenever the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else if (load) begin
      m_tvalid <= q_valid;
      if (q_valid) idx <= last_slot ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      cp_q    <= res[idx].cp;
      m_tuser <= res[idx].rep;
      m_tlast <= last_slot;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst) q_valid |-> idx < res_cnt)
    else $error("result index beyond job result count");
  a_pop_ends_run: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid && m_tlast)
    else $error("job retired without end-of-run beat");
  a_repl_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> cp_q == REPL_CP)
    else $error("replacement beat carries wrong code point");
  a_scalar: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cp_q <= 21'h10FFFF && !(cp_q >= 21'h00D800 && cp_q <= 21'h00DFFF))
    else $error("output is not a Unicode scalar value");

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder with replacement.
//
//  Channel   Dir  Signals                       Contents
//  s_*       in   tvalid tready tdata tlast     tdata[7:0] byte_in, tlast last_byte
//  m_*       out  tvalid tready tdata tuser     tdata[20:0] code_point, tuser replaced,
//                 tlast                         tlast end_of_run
//
//  One input beat per cycle while the job queue has room; one output beat per cycle
//  while m_tready is high. A byte that ends a sequence, or a lone byte, costs one
//  output beat; a sequence cut at the buffer end costs two or three, set by the job's
//  result count. An input beat passes the queue, then the output register.
//  Reset clears the open sequence, the queue and the output register; held bytes are
//  not cleared. A stall on m_* backs up into the queue and then drops s_tready.
`default_nettype none

module utf8_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::U8D_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
  output logic             m_tuser,   // replaced
  output logic             m_tlast    // end_of_run
);

  import u8d_pkg::*;

  localparam int unsigned JOB_W = $bits(job_t);

  logic       q_full;
  logic       q_push;
  job_t       q_push_job;
  logic       q_pop;
  logic       q_valid;
  logic [JOB_W-1:0] q_head_bits;
  job_t       q_head;

  assign q_head = job_t'(q_head_bits);

  u8d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_push_job)
  );

  u8d_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head_bits),
    .not_empty (q_valid)
  );

  u8d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
